### hw/rtl/dcr_pkg.sv
// Shared constants, codes and types for the dendrogram cluster relabel unit.
package dcr_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int LABEL_BITS  = 16;
	localparam int MERGE_DEPTH = MAX_SAMPLES - 1;
	localparam int SLOT_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int MIDX_W      = $clog2(MERGE_DEPTH);
	localparam int CFG_W       = 9;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_MERGE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef logic [LABEL_BITS-1:0] label_t;

	// ring control: rotate the ring by one and feed the tail cell
	typedef struct packed {
		logic   shift;
		label_t tail;
	} ring_ctl_t;

endpackage

### hw/rtl/dendrogram_cluster_relabel_unit.sv
// Top level: command decode, merge sequencing, merge label store, sample ring.
//
//  channel   | signals                                              | handshake
//  ----------+------------------------------------------------------+------------------
//  command   | action sample_index label_value left_ref right_ref  | start & !busy
//  result    | out_label applied                                   | done, one cycle
//  config    | cfg_index cfg_data                                  | cfg_we
//
// Items that do nothing (slot out of range, rejected merge, unused action) answer
// on the cycle after acceptance. A load or read takes one full ring rotation, then
// a decide state; a merge takes two rotations with a decide state between them:
// one pass to fetch singleton labels, one pass to relabel.
// Reset clears control state only; label stores are undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
module dendrogram_cluster_relabel_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [8:0]        cfg_data,
	input  logic [1:0]        action,
	input  logic [7:0]        sample_index,
	input  logic [15:0]       label_value,
	input  logic signed [8:0] left_ref,
	input  logic signed [8:0] right_ref,
	output logic [15:0]       out_label,
	output logic              applied
);
	import dcr_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_SWEEP  = 2'd3;

	localparam logic [SLOT_W-1:0] POS_LAST = SLOT_W'(MAX_SAMPLES - 1);

	logic [1:0]        state_q;
	logic [1:0]        op_q;
	logic [SLOT_W-1:0] idx_q;
	label_t            lab_in_q;
	logic              ls_q, rs_q;
	logic [SLOT_W-1:0] lslot_q, rslot_q;
	label_t            lcap_q, rcap_q;
	label_t            mem_l_s1, mem_r_s1;
	logic              sw_single_q;
	logic [SLOT_W-1:0] sw_slot_q;
	label_t            sw_from_q, sw_to_q, win_q;
	logic [SLOT_W-1:0] hpos_q, cnt_q;
	logic [CNT_W-1:0]  count_q, merges_q;
	logic [CFG_W-1:0]  target_q;
	logic              done_q, applied_q;
	label_t            out_q;

	label_t            merge_mem [MERGE_DEPTH];

	ring_ctl_t ctl;
	label_t    head;

	logic acc, idx_ok, room, merge_ok;
	logic l_sv, l_cv, l_ok, r_sv, r_cv, r_ok;
	logic [7:0] l_s, r_s;
	logic hit, pass_last, mem_we;
	label_t la, ra, win_d;

	dcr_chain u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

	assign busy = (state_q != ST_IDLE);
	assign acc  = start && !busy;

	// command checks at acceptance
	assign idx_ok = 32'(sample_index) < 32'(count_q);
	assign l_s    = ~left_ref[7:0];
	assign r_s    = ~right_ref[7:0];
	assign l_sv   = 32'(l_s) < 32'(count_q);
	assign r_sv   = 32'(r_s) < 32'(count_q);
	assign l_cv   = (left_ref != 9'sd0) && (32'($unsigned(left_ref)) <= 32'(merges_q));
	assign r_cv   = (right_ref != 9'sd0) && (32'($unsigned(right_ref)) <= 32'(merges_q));
	assign l_ok   = left_ref[8] ? l_sv : l_cv;
	assign r_ok   = right_ref[8] ? r_sv : r_cv;
	assign room   = ((CNT_W+1)'(merges_q) + (CNT_W+1)'(target_q) < (CNT_W+1)'(count_q))
		&& (32'(merges_q) < MERGE_DEPTH);
	assign merge_ok = room && l_ok && r_ok;

	// resolved labels of both sides for the decision
	assign la = ls_q ? lcap_q : mem_l_s1;
	assign ra = rs_q ? rcap_q : mem_r_s1;

	// smaller label wins; on a tie the left label is kept
	assign win_d = (la > ra) ? ra : la;

	assign pass_last = (cnt_q == POS_LAST);
	assign mem_we    = (state_q == ST_DECIDE) && (op_q == ACT_MERGE);

	// ring rotation and rewrite of the label that wraps to the tail
	always_comb begin
		ctl.shift = (state_q == ST_SCAN) || (state_q == ST_SWEEP);
		ctl.tail  = head;
		hit       = 1'b0;
		if (state_q == ST_SCAN) begin
			if (op_q == ACT_LOAD && hpos_q == idx_q) begin
				ctl.tail = lab_in_q;
			end
		end else if (state_q == ST_SWEEP) begin
			if (sw_single_q) begin
				hit = (hpos_q == sw_slot_q);
			end else begin
				hit = (32'(hpos_q) < 32'(count_q)) && (head == sw_from_q);
			end
			if (hit) begin
				ctl.tail = sw_to_q;
			end
		end
	end

	// merge label store, two registered reads at acceptance
	always_ff @(posedge clk) begin
		if (mem_we) begin
			merge_mem[MIDX_W'(merges_q)] <= win_d;
		end
		if (acc) begin
			mem_l_s1 <= merge_mem[MIDX_W'(left_ref[7:0] - 8'd1)];
			mem_r_s1 <= merge_mem[MIDX_W'(right_ref[7:0] - 8'd1)];
		end
	end

	// item payload and per-pass working registers
	always_ff @(posedge clk) begin
		if (acc) begin
			op_q     <= action;
			idx_q    <= SLOT_W'(sample_index);
			lab_in_q <= LABEL_BITS'(label_value);
			ls_q     <= left_ref[8];
			rs_q     <= right_ref[8];
			lslot_q  <= SLOT_W'(l_s);
			rslot_q  <= SLOT_W'(r_s);
		end
		if (state_q == ST_SCAN) begin
			if (op_q == ACT_READ && hpos_q == idx_q) begin
				lcap_q <= head;
			end
			if (op_q == ACT_MERGE && ls_q && hpos_q == lslot_q) begin
				lcap_q <= head;
			end
			if (op_q == ACT_MERGE && rs_q && hpos_q == rslot_q) begin
				rcap_q <= head;
			end
		end
		if (state_q == ST_DECIDE) begin
			// larger label loses; on a tie the right side is rewritten
			if (la > ra) begin
				sw_single_q <= ls_q;
				sw_slot_q   <= lslot_q;
				sw_from_q   <= la;
				sw_to_q     <= ra;
				win_q       <= ra;
			end else begin
				sw_single_q <= rs_q;
				sw_slot_q   <= rslot_q;
				sw_from_q   <= ra;
				sw_to_q     <= la;
				win_q       <= la;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_W'(MAX_SAMPLES);
			target_q <= CFG_W'(10);
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				if (cfg_data == '0) begin
					count_q <= CNT_W'(1);
				end else if (32'(cfg_data) > MAX_SAMPLES) begin
					count_q <= CNT_W'(MAX_SAMPLES);
				end else begin
					count_q <= CNT_W'(cfg_data);
				end
			end else begin
				target_q <= cfg_data;
			end
		end
	end

	// sequencer, ring position, merge count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			hpos_q    <= '0;
			cnt_q     <= '0;
			merges_q  <= '0;
			done_q    <= 1'b0;
			applied_q <= 1'b0;
			out_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.shift) begin
				hpos_q <= (hpos_q == POS_LAST) ? '0 : hpos_q + SLOT_W'(1);
				cnt_q  <= pass_last ? '0 : cnt_q + SLOT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= '0;
						unique case (action) inside
							ACT_LOAD, ACT_READ: begin
								if (idx_ok) begin
									state_q <= ST_SCAN;
								end else begin
									done_q    <= 1'b1;
									applied_q <= 1'b0;
									out_q     <= '0;
								end
							end
							ACT_MERGE: begin
								if (merge_ok) begin
									state_q <= ST_SCAN;
								end else begin
									done_q    <= 1'b1;
									applied_q <= 1'b0;
									out_q     <= '0;
								end
							end
							default: begin
								done_q    <= 1'b1;
								applied_q <= 1'b0;
								out_q     <= '0;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (pass_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == ACT_MERGE) begin
						merges_q <= merges_q + CNT_W'(1);
						state_q  <= ST_SWEEP;
					end else begin
						done_q    <= 1'b1;
						applied_q <= 1'b0;
						out_q     <= (op_q == ACT_LOAD) ? lab_in_q : lcap_q;
						state_q   <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (pass_last) begin
						done_q    <= 1'b1;
						applied_q <= 1'b1;
						out_q     <= win_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done      = done_q;
	assign applied   = applied_q;
	assign out_label = 16'(out_q);

	// a result never shows while an item is still in work
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the merge store never overflows
	a_merge_cap: assert property (@(posedge clk) disable iff (!arst_n)
		32'(merges_q) <= MERGE_DEPTH)
		else $error("merge count beyond store depth");

	// the end of a relabel sweep always yields an applied merge
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && pass_last) |=> (done && applied))
		else $error("sweep ended without applied result");

	// a full pass leaves the ring position where it started
	a_ring_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (hpos_q == $past(hpos_q, MAX_SAMPLES)))
		else $error("ring position drifted over a pass");

endmodule

### hw/rtl/dcr_cell.sv
// One label cell of the rotating sample ring.
module dcr_cell (
	input  logic            clk,
	input  logic            shift,
	input  dcr_pkg::label_t d,
	output dcr_pkg::label_t q
);
	import dcr_pkg::*;

	label_t lab_q;

	// take the neighbor's label when the ring rotates
	always_ff @(posedge clk) begin
		if (shift) begin
			lab_q <= d;
		end
	end

	assign q = lab_q;

endmodule

### hw/rtl/dcr_chain.sv
// Ring of sample label cells; the head cell is read, the tail cell is fed.
module dcr_chain (
	input  logic              clk,
	input  dcr_pkg::ring_ctl_t ctl,
	output dcr_pkg::label_t   head
);
	import dcr_pkg::*;

	label_t cell_q [MAX_SAMPLES];

	// cell i takes from cell i+1; the last cell takes the rewritten head
	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		label_t d;
		if (i == MAX_SAMPLES - 1) begin : g_tail
			assign d = ctl.tail;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		dcr_cell u_cell (
			.clk   (clk),
			.shift (ctl.shift),
			.d     (d),
			.q     (cell_q[i])
		);
	end

	assign head = cell_q[0];

endmodule
